### rtl/core/hrcp_pkg.sv
// Package for the hex register command parser: parser states, bus operation codes, characters.
package hrcp_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READY,
		ST_REG_HI,
		ST_REG,
		ST_GET,
		ST_CNT_HI,
		ST_CNT,
		ST_BURST,
		ST_SAME,
		ST_SET,
		ST_DATA_HI,
		ST_DATA,
		ST_SHIFT,
		ST_BITS
	} parse_state_t;

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_BURST  = 3'd1,
		OP_REPEAT = 3'd2,
		OP_WRITE  = 3'd3,
		OP_RMW    = 3'd4
	} op_t;

	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_END   = 8'h3B;
	localparam logic [7:0] CH_GET   = 8'h67;
	localparam logic [7:0] CH_SET   = 8'h73;
	localparam logic [7:0] CH_BURST = 8'h62;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] ALPHA_OFS = 8'h37;
	localparam logic [7:0] MASK_ALL = 8'hFF;
	localparam logic [3:0] MAX_BITS = 4'd8;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Upper-case hex digit decode.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			r.ok = 1'b1;
			r.val = d[3:0];
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - ALPHA_OFS;
			r.ok = 1'b1;
			r.val = d[3:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/hex_register_command_parser.sv
// Top level of the hex register command parser.
// Parses '#HH;' (read), '#HHgCCb;' (burst), '#HHgCCs;' (repeated read), '#HHsDD;' (write)
// and '#HHsDDSN;' (read-modify-write) from a byte stream, one bus request per finished
// command. Each byte is registered at the input, goes through the parser state update and
// its result is registered at the output; with no output stall a byte is taken every cycle,
// and a request is offered once its final ';' has passed the input register and the output
// register. An output stall holds the parser and the input register. Unexpected bytes drop
// the command silently.
module hex_register_command_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] op,
	output logic [7:0] reg_addr,
	output logic [7:0] count,
	output logic [7:0] or_mask,
	output logic [7:0] clear_mask
);
	import hrcp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         proc;
	logic         out_free;

	parse_state_t state_q, state_d;
	logic [7:0]   reg_q, reg_d;
	logic [7:0]   cnt_q, cnt_d;
	logic [7:0]   data_q, data_d;
	logic [3:0]   shift_q, shift_d;
	logic [3:0]   bits_q, bits_d;

	logic         emit;
	op_t          op_d;
	logic [7:0]   count_d;
	logic [7:0]   set_d;
	logic [7:0]   clr_d;

	hex_t         hx;
	logic [3:0]   nb;
	logic [8:0]   field_mask;
	logic [15:0]  clr_wide;
	logic [15:0]  set_wide;

	op_t          op_q;
	logic [7:0]   reg_out_q;
	logic [7:0]   count_q;
	logic [7:0]   set_q;
	logic [7:0]   clr_q;
	logic         out_valid_q;

	assign out_free = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			reg_q   <= '0;
			cnt_q   <= '0;
			data_q  <= '0;
			shift_q <= '0;
			bits_q  <= '0;
		end else if (proc) begin
			state_q <= state_d;
			reg_q   <= reg_d;
			cnt_q   <= cnt_d;
			data_q  <= data_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
		end
	end

	always_comb begin
		hx = hex_decode(byte_s1);
		nb = (bits_q > MAX_BITS) ? MAX_BITS : bits_q;
		field_mask = (9'd1 << nb) - 9'd1;
		clr_wide = {8'd0, field_mask[7:0]} << shift_q;
		set_wide = {8'd0, data_q} << shift_q;

		state_d = ST_IDLE;
		reg_d   = reg_q;
		cnt_d   = cnt_q;
		data_d  = data_q;
		shift_d = shift_q;
		bits_d  = bits_q;
		emit    = 1'b0;
		op_d    = OP_READ;
		count_d = '0;
		set_d   = '0;
		clr_d   = '0;

		case (state_q)
			ST_IDLE: begin
				if (byte_s1 == CH_START) state_d = ST_READY;
			end
			ST_READY: begin
				if (hx.ok) begin
					reg_d = {hx.val, 4'd0};
					state_d = ST_REG_HI;
				end
			end
			ST_REG_HI: begin
				if (hx.ok) begin
					reg_d = reg_q + {4'd0, hx.val};
					state_d = ST_REG;
				end
			end
			ST_REG: begin
				if (byte_s1 == CH_GET) state_d = ST_GET;
				else if (byte_s1 == CH_SET) state_d = ST_SET;
				else if (byte_s1 == CH_END) begin
					emit = 1'b1;
					op_d = OP_READ;
					count_d = 8'd1;
				end
			end
			ST_GET: begin
				if (hx.ok) begin
					cnt_d = {hx.val, 4'd0};
					state_d = ST_CNT_HI;
				end
			end
			ST_CNT_HI: begin
				if (hx.ok) begin
					cnt_d = cnt_q + {4'd0, hx.val};
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				if (byte_s1 == CH_BURST) state_d = ST_BURST;
				else if (byte_s1 == CH_SET) state_d = ST_SAME;
			end
			ST_BURST: begin
				if (byte_s1 == CH_END) begin
					emit = 1'b1;
					op_d = OP_BURST;
					count_d = cnt_q;
				end
			end
			ST_SAME: begin
				if (byte_s1 == CH_END) begin
					emit = 1'b1;
					op_d = OP_REPEAT;
					count_d = cnt_q;
				end
			end
			ST_SET: begin
				if (hx.ok) begin
					data_d = {hx.val, 4'd0};
					state_d = ST_DATA_HI;
				end
			end
			ST_DATA_HI: begin
				if (hx.ok) begin
					data_d = data_q + {4'd0, hx.val};
					state_d = ST_DATA;
				end
			end
			ST_DATA: begin
				if (hx.ok) begin
					shift_d = hx.val;
					state_d = ST_SHIFT;
				end else if (byte_s1 == CH_END) begin
					emit = 1'b1;
					op_d = OP_WRITE;
					set_d = data_q;
					clr_d = MASK_ALL;
				end
			end
			ST_SHIFT: begin
				if (hx.ok) begin
					bits_d = hx.val;
					state_d = ST_BITS;
				end
			end
			ST_BITS: begin
				if (byte_s1 == CH_END) begin
					emit = 1'b1;
					op_d = OP_RMW;
					set_d = set_wide[7:0];
					clr_d = clr_wide[7:0];
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && proc && emit) begin
			op_q      <= op_d;
			reg_out_q <= reg_q;
			count_q   <= count_d;
			set_q     <= set_d;
			clr_q     <= clr_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign op         = op_q;
	assign reg_addr   = reg_out_q;
	assign count      = count_q;
	assign or_mask    = set_q;
	assign clear_mask = clr_q;

endmodule

### rtl/core/hrcp_checker.sv
// Port-level checker for the hex register command parser and its bind.
module hrcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] op,
	input logic [7:0] reg_addr,
	input logic [7:0] count,
	input logic [7:0] or_mask,
	input logic [7:0] clear_mask
);
	import hrcp_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input transaction changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(op) && $stable(reg_addr)
			&& $stable(count) && $stable(or_mask) && $stable(clear_mask))
		else $error("stalled result transaction changed");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op == OP_READ |-> count == 8'd1 && or_mask == 8'd0 && clear_mask == 8'd0)
		else $error("single read carries wrong fields");

	a_multi_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (op == OP_BURST || op == OP_REPEAT)
			|-> or_mask == 8'd0 && clear_mask == 8'd0)
		else $error("multi read carries write fields");

	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (op == OP_WRITE || op == OP_RMW)
			|-> count == 8'd0 && (op == OP_RMW || clear_mask == MASK_ALL))
		else $error("write carries wrong fields");

endmodule

bind hex_register_command_parser hrcp_checker u_hrcp_checker (.*);
